/* rtl/ffba_pkg.sv */
// Shared types and constants of the first-fit bitmap allocator.
package ffba_pkg;

    // Map word geometry: the map is read and written one word at a time.
    localparam int WORD_BITS = 32;
    localparam int WORD_LSB  = 5;

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic        opcode;
        logic [9:0]  start_unit;
        logic [10:0] run_length;
    } ffba_req_t;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [9:0] granted_unit;
        logic       failed;
    } ffba_rsp_t;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_MARK  = 5'b01000,
        ST_DONE  = 5'b10000
    } ffba_state_t;

endpackage

/* rtl/ffba_map_ram.sv */
// Word-wide used/free map storage with one write port and one registered read port.
module ffba_map_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [ffba_pkg::WORD_BITS-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [ffba_pkg::WORD_BITS-1:0] wr_data
);
    import ffba_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/ffba_run_scan.sv */
// Free-run search over one map word, carrying the run length from the previous word.
module ffba_run_scan #(
    parameter int EW = 12
) (
    input  logic [ffba_pkg::WORD_BITS-1:0] used_bits,
    input  logic [EW-1:0]                  run_in,
    input  logic [EW-1:0]                  run_len,
    output logic                           found,
    output logic [ffba_pkg::WORD_LSB-1:0]  pos,
    output logic [EW-1:0]                  run_out
);
    import ffba_pkg::*;

    logic                any_lvl  [WORD_LSB+1][WORD_BITS];
    logic [WORD_LSB-1:0] last_lvl [WORD_LSB+1][WORD_BITS];
    logic [EW-1:0]       run_at   [WORD_BITS];
    logic [WORD_BITS-1:0] hit;

    // Parallel prefix: for each bit, whether any used bit lies at or below it,
    // and the position of the highest such used bit.
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            any_lvl[0][i]  = used_bits[i];
            last_lvl[0][i] = WORD_LSB'(i);
        end
        for (int d = 0; d < WORD_LSB; d++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i >= (1 << d) && !any_lvl[d][i]) begin
                    any_lvl[d+1][i]  = any_lvl[d][i - (1 << d)];
                    last_lvl[d+1][i] = last_lvl[d][i - (1 << d)];
                end else begin
                    any_lvl[d+1][i]  = any_lvl[d][i];
                    last_lvl[d+1][i] = last_lvl[d][i];
                end
            end
        end
    end

    // Run length ending at each bit, and whether it reaches the request.
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            if (any_lvl[WORD_LSB][i]) begin
                run_at[i] = EW'(WORD_LSB'(i) - last_lvl[WORD_LSB][i]);
            end else begin
                run_at[i] = run_in + EW'(i + 1);
            end
            hit[i] = (run_at[i] >= run_len);
        end
    end

    // Lowest bit at which the run completes.
    always_comb begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                pos = WORD_LSB'(i);
            end
        end
    end

    assign found   = |hit;
    assign run_out = run_at[WORD_BITS-1];

endmodule

/* rtl/first_fit_bitmap_allocator_top.sv */
// Top level of the first-fit bitmap allocator: request sequencer, map RAM and word scanner.
//
// The allocator keeps one used/free bit per unit in a RAM of 32-bit words and
// handles one request at a time. After reset a clearing pass writes one map
// word per cycle, before the first request is taken. An allocate request reads
// the map one word per cycle from word 0 and checks all 32 bits of a word at
// once, so the scan stops at the word where the run ends, having read at most
// 32 words for 1024 units; the run is then marked used with one
// read-modify-write per word it covers, pipelined at one word per cycle. An
// allocate of zero length or longer than the store fails without a scan, and
// a free of zero length goes straight to the result. The block returns to idle,
// ready for the next request, as the result is loaded into the output register.
// The single map RAM read port, one word per cycle, limits the scan and mark
// speed. The result sits in an output register, and the next request is taken
// while it waits.
module first_fit_bitmap_allocator_top #(
    parameter int UNIT_COUNT = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffba_pkg::ffba_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffba_pkg::ffba_rsp_t m_data
);
    import ffba_pkg::*;

    localparam int WORD_COUNT = (UNIT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int UW         = $clog2(UNIT_COUNT) + 1;
    localparam int EW         = (UW > 12) ? UW : 12;
    localparam int XW         = EW - WORD_LSB;
    localparam int TAIL       = UNIT_COUNT % WORD_BITS;

    localparam logic [WW:0]   WORD_END  = (WW+1)'(WORD_COUNT);
    localparam logic [WW-1:0] LAST_WORD = WW'(WORD_COUNT - 1);
    localparam logic [EW-1:0] UNITS     = EW'(UNIT_COUNT);
    localparam logic [EW-1:0] TOP_UNIT  = EW'(UNIT_COUNT - 1);

    ffba_state_t   state_reg, state_next;
    logic [WW:0]   ptr_reg, ptr_next;
    logic          rd_valid_reg;
    logic [WW-1:0] rd_word_reg;
    logic [EW-1:0] run_reg, run_next;
    logic [EW-1:0] len_reg, len_next;
    logic [EW-1:0] lo_reg, lo_next;
    logic [EW-1:0] hi_reg, hi_next;
    logic          set_reg, set_next;
    ffba_rsp_t     res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    ffba_rsp_t     m_data_reg, m_data_next;

    logic                 rd_en;
    logic [WW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [WORD_BITS-1:0] scan_bits;
    logic                 scan_found;
    logic [WORD_LSB-1:0]  scan_pos;
    logic [EW-1:0]        scan_run;
    logic                 scan_eval;
    logic                 scan_leave;
    logic [EW-1:0]        scan_end;
    logic [EW-1:0]        scan_first;

    logic                 mark_eval;
    logic                 mark_done;
    logic [XW-1:0]        rd_word_ext;
    logic [XW-1:0]        ptr_ext;
    logic [WORD_LSB-1:0]  lo_bit;
    logic [WORD_LSB-1:0]  hi_bit;
    logic [WORD_BITS-1:0] mark_mask;

    logic [EW-1:0] req_start;
    logic [EW-1:0] req_len;
    logic [EW-1:0] req_end;

    // Map storage.
    ffba_map_ram #(
        .DEPTH (WORD_COUNT),
        .AW    (WW)
    ) u_map_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Units past the store's end read as used so that no run reaches them.
    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            scan_bits[k] = rd_data[k]
                         | ((TAIL != 0) && (k >= TAIL) && (rd_word_reg == LAST_WORD));
        end
    end

    // Word scanner.
    ffba_run_scan #(
        .EW (EW)
    ) u_run_scan (
        .used_bits (scan_bits),
        .run_in    (run_reg),
        .run_len   (len_reg),
        .found     (scan_found),
        .pos       (scan_pos),
        .run_out   (scan_run)
    );

    // Scan bookkeeping: a word is checked in the cycle after its read.
    assign scan_eval  = (state_reg == ST_SCAN) && rd_valid_reg;
    assign scan_leave = scan_eval && (scan_found || (rd_word_reg == LAST_WORD));
    assign scan_end   = EW'({rd_word_reg, scan_pos});
    assign scan_first = scan_end + EW'(1) - len_reg;

    // Mark bookkeeping: each word of the range is read, modified and written.
    assign rd_word_ext = XW'(rd_word_reg);
    assign ptr_ext     = XW'(ptr_reg);
    assign mark_eval   = (state_reg == ST_MARK) && rd_valid_reg;
    assign mark_done   = mark_eval && (rd_word_ext == hi_reg[EW-1:WORD_LSB]);
    assign lo_bit      = (rd_word_ext == lo_reg[EW-1:WORD_LSB]) ? lo_reg[WORD_LSB-1:0] : '0;
    assign hi_bit      = (rd_word_ext == hi_reg[EW-1:WORD_LSB]) ? hi_reg[WORD_LSB-1:0] : '1;

    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            mark_mask[k] = (WORD_LSB'(k) >= lo_bit) && (WORD_LSB'(k) <= hi_bit);
        end
    end

    // Map RAM port control.
    always_comb begin
        rd_addr = ptr_reg[WW-1:0];
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = rd_word_reg;
        wr_data = set_reg ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[WW-1:0];
                wr_data = '0;
            end
            ST_SCAN: begin
                rd_en = (ptr_reg < WORD_END) && !scan_leave;
            end
            ST_MARK: begin
                rd_en = (ptr_ext <= hi_reg[EW-1:WORD_LSB]);
                wr_en = mark_eval;
            end
            default: begin
            end
        endcase
    end

    // Request fields widened to unit-index width.
    assign req_start = EW'(s_data.start_unit);
    assign req_len   = EW'(s_data.run_length);
    assign req_end   = req_start + req_len - EW'(1);

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        run_next     = run_reg;
        len_next     = len_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        set_next     = set_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (rd_en) begin
            ptr_next = ptr_reg + (WW+1)'(1);
        end
        case (state_reg)
            ST_CLEAR: begin
                ptr_next = ptr_reg + (WW+1)'(1);
                if (ptr_reg[WW-1:0] == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    res_next = '0;
                    len_next = req_len;
                    run_next = '0;
                    if (s_data.opcode == OP_ALLOC) begin
                        if (req_len == '0 || req_len > UNITS) begin
                            res_next.failed = 1'b1;
                            state_next      = ST_DONE;
                        end else begin
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end else begin
                        set_next = 1'b0;
                        lo_next  = req_start;
                        hi_next  = (req_end > TOP_UNIT) ? TOP_UNIT : req_end;
                        ptr_next = (WW+1)'(req_start[EW-1:WORD_LSB]);
                        if (req_len == '0 || req_start >= UNITS) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_MARK;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (scan_eval) begin
                    run_next = scan_run;
                    if (scan_found) begin
                        set_next              = 1'b1;
                        lo_next               = scan_first;
                        hi_next               = scan_end;
                        ptr_next              = (WW+1)'(scan_first[EW-1:WORD_LSB]);
                        res_next.granted_unit = scan_first[9:0];
                        state_next            = ST_MARK;
                    end else if (rd_word_reg == LAST_WORD) begin
                        res_next.failed = 1'b1;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_MARK: begin
                if (mark_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            rd_valid_reg <= rd_en;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_word_reg <= rd_addr;
        run_reg     <= run_next;
        len_reg     <= len_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        set_reg     <= set_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
